// ===== hdl/rtn_pkg.sv =====
// rtn_pkg: shared widths, event and action codes, config layout and result record
// for the radio timeslot negotiator; no dependencies
`default_nettype none

package rtn_pkg;

    // field widths
    localparam int RTC_IN_W   = 24;
    localparam int RTC_BITS   = 24;
    localparam int TIME_BITS  = 32;
    localparam int OUT_TIME_W = 32;
    localparam int LEN_W      = 24;
    localparam int PPM_W      = 9;
    localparam int MODE_W     = 4;
    localparam int ACT_W      = 3;
    localparam int FWD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int COUNT_W    = 32;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // rtc ticks to microseconds: 1000000 / 32768 = 15625 / 512
    localparam int RTC_MUL_W = 14;
    localparam logic [RTC_MUL_W-1:0] RTC_MUL = RTC_MUL_W'(15625);
    localparam int RTC_SHIFT = 9;
    localparam int RTC_PROD_W = RTC_BITS + RTC_MUL_W;

    // drift margin: len * ppm / 1000000 = ((len * ppm) >> 6) / 15625
    localparam int PROD_W    = LEN_W + PPM_W;
    localparam int PRE_SHIFT = 6;
    localparam int Y_W       = PROD_W - PRE_SHIFT;
    localparam longint unsigned PPM_DIV = 64'd15625;
    localparam int DIV_SHIFT = 40;
    localparam longint unsigned DIV_RECIP_VAL = (64'd1 << DIV_SHIFT) / PPM_DIV;
    localparam int RECIP_W = $clog2(DIV_RECIP_VAL + 1);
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(DIV_RECIP_VAL);
    localparam int Q_W = $clog2((64'd1 << PROD_W) / 64'd1000000 + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_START     = 4'd0,
        MODE_RADIO     = 4'd1,
        MODE_TIMER     = 4'd2,
        MODE_EXT_OK    = 4'd3,
        MODE_EXT_FAIL  = 4'd4,
        MODE_END_TIMER = 4'd5,
        MODE_IDLE      = 4'd6,
        MODE_BLOCKED   = 4'd7,
        MODE_CANCELLED = 4'd8,
        MODE_STOP      = 4'd9,
        MODE_RESTART   = 4'd10,
        MODE_RESUME    = 4'd11
    } t_mode;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_END     = 3'd1,
        ACT_RENEW   = 3'd2,
        ACT_EXTEND  = 3'd3,
        ACT_REQUEST = 3'd4
    } t_action;

    typedef enum logic [FWD_W-1:0] {
        FWD_NONE  = 2'd0,
        FWD_RADIO = 2'd1,
        FWD_TIMER = 2'd2
    } t_fwd;

    typedef enum logic [1:0] {
        FC_NONE    = 2'd0,
        FC_STOP    = 2'd1,
        FC_RESTART = 2'd2
    } t_forced;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PPM       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EMERGENCY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIRST = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RETRY = 3'd7;

    typedef struct packed {
        logic [PPM_W-1:0] ppm;
        logic [LEN_W-1:0] margin;
        logic [LEN_W-1:0] base;
        logic [LEN_W-1:0] step;
        logic [LEN_W-1:0] emergency;
        logic [LEN_W-1:0] max_total;
        logic [LEN_W-1:0] max_first;
        logic [LEN_W-1:0] min_retry;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        ppm:       PPM_W'(250),
        margin:    LEN_W'(1000),
        base:      LEN_W'(10000),
        step:      LEN_W'(10000),
        emergency: LEN_W'(6000),
        max_total: LEN_W'(10000000),
        max_first: LEN_W'(10000),
        min_retry: LEN_W'(1000)
    };

    // one event's outcome, deadline still to be worked out
    typedef struct packed {
        t_action              action;
        logic [LEN_W-1:0]     ext;
        logic [LEN_W-1:0]     req;
        logic                 armed;
        logic [LEN_W-1:0]     dlen;
        logic [TIME_BITS-1:0] start;
        logic [LEN_W-1:0]     slot_len;
        logic                 in_slot;
        logic                 ended;
        t_fwd                 fwd;
        logic                 status;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/rtn_core.sv =====
// rtn_core: slot state registers and the per-event decision logic
// depends on rtn_pkg
`default_nettype none

module rtn_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rtn_pkg::t_cfg              i_cfg,
    input  logic                       i_en,
    input  logic [rtn_pkg::MODE_W-1:0] i_mode,
    input  logic [rtn_pkg::RTC_IN_W-1:0] i_rtc,
    output rtn_pkg::t_result           o_result
);
    import rtn_pkg::*;

    logic [TIME_BITS-1:0]  r_start,   n_start;
    logic [LEN_W-1:0]      r_len,     n_len;
    logic [LEN_W-1:0]      r_step,    n_step;
    logic [LEN_W-1:0]      r_pend,    n_pend;
    logic [RTC_BITS-1:0]   r_last,    n_last;
    logic [COUNT_W-1:0]    r_count,   n_count;
    logic                  r_inp,     n_inp;
    logic                  r_endf,    n_endf;
    t_forced               r_forced,  n_forced;

    logic [RTC_BITS-1:0]   rtc_s;
    logic [RTC_BITS-1:0]   rtc_ref;
    logic [RTC_BITS-1:0]   delta;
    logic [RTC_PROD_W-1:0] rtc_prod;
    logic [LEN_W:0]        len_sum;
    logic [LEN_W-1:0]      len_sat;
    logic [LEN_W-1:0]      half_step;
    logic [LEN_W-1:0]      ext_limit;
    t_result               res;

    // clamp a requested extension so the slot stays within the total limit
    function automatic logic [LEN_W-1:0] clamp_ext(input logic [LEN_W-1:0] len,
                                                   input logic [LEN_W-1:0] extra,
                                                   input logic [LEN_W-1:0] max_total);
        logic [LEN_W:0] sum;
        sum = {1'b0, len} + {1'b0, extra};
        if (sum > {1'b0, max_total}) begin
            return (max_total > len) ? max_total - len : '0;
        end
        return extra;
    endfunction

    assign rtc_s     = RTC_BITS'(i_rtc);
    assign rtc_ref   = (r_count == '0) ? rtc_s : r_last;
    assign delta     = rtc_s - rtc_ref;
    assign rtc_prod  = RTC_PROD_W'(delta) * RTC_PROD_W'(RTC_MUL);
    assign len_sum   = {1'b0, r_len} + {1'b0, r_pend};
    assign len_sat   = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
    assign half_step = r_step >> 1;
    assign ext_limit = (r_count == COUNT_W'(1)) ? i_cfg.max_first : i_cfg.max_total;

    always_comb begin
        n_start  = r_start;
        n_len    = r_len;
        n_step   = r_step;
        n_pend   = r_pend;
        n_last   = r_last;
        n_count  = r_count;
        n_inp    = r_inp;
        n_endf   = r_endf;
        n_forced = r_forced;

        res        = '0;
        res.action = ACT_NONE;
        res.fwd    = FWD_NONE;
        res.dlen   = r_len;

        if (i_mode inside {[MODE_START:MODE_EXT_FAIL]}) begin
            if (r_forced == FC_STOP) begin
                res.action = ACT_END;
                n_count    = '0;
                n_inp      = 1'b0;
                n_endf     = 1'b0;
                res.ended  = 1'b1;
            end else if (r_forced == FC_RESTART) begin
                res.action = ACT_RENEW;
                res.req    = i_cfg.base;
                n_len      = i_cfg.base;
                n_inp      = 1'b0;
                n_endf     = 1'b0;
                res.ended  = 1'b1;
                n_forced   = FC_NONE;
            end else begin
                case (i_mode)
                    MODE_START: begin
                        n_inp      = 1'b1;
                        n_endf     = 1'b0;
                        n_start    = r_start + TIME_BITS'(rtc_prod >> RTC_SHIFT);
                        n_last     = rtc_s;
                        n_step     = i_cfg.step;
                        res.armed  = 1'b1;
                        res.dlen   = r_len;
                        res.action = ACT_EXTEND;
                        res.ext    = clamp_ext(r_len, i_cfg.step, i_cfg.max_total);
                        n_count    = (r_count == '1) ? COUNT_W'(1) : r_count + COUNT_W'(1);
                    end
                    MODE_RADIO: begin
                        res.fwd = FWD_RADIO;
                    end
                    MODE_TIMER: begin
                        res.fwd = FWD_TIMER;
                    end
                    MODE_EXT_OK: begin
                        // granted extension is used up
                        n_len     = len_sat;
                        n_pend    = '0;
                        res.armed = 1'b1;
                        res.dlen  = len_sat;
                        if (({1'b0, len_sat} + {1'b0, r_step}) < {1'b0, ext_limit}) begin
                            res.action = ACT_EXTEND;
                            res.ext    = clamp_ext(len_sat, r_step, i_cfg.max_total);
                        end
                    end
                    default: begin
                        // extension refused
                        n_step = half_step;
                        if (half_step > i_cfg.min_retry) begin
                            res.action = ACT_EXTEND;
                            res.ext    = clamp_ext(r_len, half_step, i_cfg.max_total);
                        end
                    end
                endcase

                if (n_endf) begin
                    res.action = ACT_RENEW;
                    res.req    = i_cfg.base;
                    n_len      = i_cfg.base;
                    n_inp      = 1'b0;
                    n_endf     = 1'b0;
                    res.ended  = 1'b1;
                end else if (res.action == ACT_EXTEND) begin
                    n_pend = res.ext;
                end else begin
                    n_pend = '0;
                end
            end
        end else begin
            case (i_mode)
                MODE_END_TIMER: begin
                    n_endf = 1'b1;
                end
                MODE_IDLE: begin
                    if (r_forced != FC_STOP) begin
                        res.action = ACT_REQUEST;
                        res.req    = i_cfg.base;
                        n_len      = i_cfg.base;
                    end
                end
                MODE_BLOCKED: begin
                    res.action = ACT_REQUEST;
                    res.req    = i_cfg.emergency;
                    n_len      = i_cfg.emergency;
                end
                MODE_CANCELLED: begin
                    res.action = ACT_REQUEST;
                    res.req    = i_cfg.base;
                    n_len      = i_cfg.base;
                end
                MODE_STOP: begin
                    n_forced = FC_STOP;
                end
                MODE_RESTART: begin
                    n_forced = FC_RESTART;
                end
                MODE_RESUME: begin
                    n_forced = FC_NONE;
                    if (r_inp) begin
                        res.status = 1'b1;
                    end else begin
                        res.action = ACT_REQUEST;
                        res.req    = i_cfg.base;
                        n_len      = i_cfg.base;
                    end
                end
                default: begin
                end
            endcase
        end

        res.start    = n_start;
        res.slot_len = n_len;
        res.in_slot  = n_inp;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_len    <= '0;
            r_step   <= LEN_W'(10000);
            r_pend   <= '0;
            r_last   <= '0;
            r_count  <= '0;
            r_inp    <= 1'b0;
            r_endf   <= 1'b0;
            r_forced <= FC_NONE;
        end else if (i_en) begin
            r_start  <= n_start;
            r_len    <= n_len;
            r_step   <= n_step;
            r_pend   <= n_pend;
            r_last   <= n_last;
            r_count  <= n_count;
            r_inp    <= n_inp;
            r_endf   <= n_endf;
            r_forced <= n_forced;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rtn_dline.sv =====
// rtn_dline: pipelined drift margin and end deadline (start + len - len*ppm/1e6 - margin)
// depends on rtn_pkg
`default_nettype none

module rtn_dline (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rtn_pkg::TIME_BITS-1:0] i_start,
    input  logic [rtn_pkg::LEN_W-1:0]     i_len,
    input  logic [rtn_pkg::PPM_W-1:0]     i_ppm,
    input  logic [rtn_pkg::LEN_W-1:0]     i_margin,
    output logic [rtn_pkg::TIME_BITS-1:0] o_deadline
);
    import rtn_pkg::*;

    localparam int RQ_W = Y_W + RECIP_W;

    logic [PROD_W-1:0]    r_prod;
    logic [TIME_BITS-1:0] r_base2;
    logic [Y_W-1:0]       r_y;
    logic [Q_W-1:0]       r_q0;
    logic [TIME_BITS-1:0] r_base3;

    logic [Y_W-1:0]       y;
    logic [RQ_W-1:0]      recip_prod;
    logic [Y_W-1:0]       rem;
    logic [Q_W-1:0]       q;
    logic [LEN_W:0]       drift;

    // reciprocal estimate is exact or one low, fixed up below
    assign y          = r_prod[PROD_W-1:PRE_SHIFT];
    assign recip_prod = RQ_W'(y) * RQ_W'(DIV_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PROD_W'(i_len) * PROD_W'(i_ppm);
            r_base2 <= i_start + TIME_BITS'(i_len);
            r_y     <= y;
            r_q0    <= recip_prod[DIV_SHIFT +: Q_W];
            r_base3 <= r_base2;
        end
    end

    assign rem        = r_y - Y_W'(Y_W'(r_q0) * Y_W'(PPM_DIV));
    assign q          = (rem >= Y_W'(PPM_DIV)) ? r_q0 + Q_W'(1) : r_q0;
    assign drift      = (LEN_W + 1)'(q) + {1'b0, i_margin};
    assign o_deadline = r_base3 - TIME_BITS'(drift);

endmodule

`default_nettype wire

// ===== hdl/radio_timeslot_negotiator.sv =====
// radio_timeslot_negotiator: top level, config registers, input register and result pipeline
// depends on rtn_pkg, rtn_core, rtn_dline
//
// usage
//   scheduler events come in on the input channel (i_valid / o_ready) as one word each:
//   i_mode and, for slot start, the sampled rtc count. every event gives exactly one
//   result word on the output channel (o_valid / i_ready): action, requested lengths,
//   slot start and length, and the drift-adjusted end deadline when the timer is armed.
//   config registers are written through i_cfg_we / i_cfg_idx / i_cfg_data, one per
//   cycle, while no event is in flight.
// pipeline and throughput
//   a word leaves the input register through r_s1, r_s2, r_s3 and the output register;
//   the slot state updates in a single pass as the word leaves the input register;
//   the deadline then needs three more stages (length times ppm, reciprocal divide
//   by 1e6, fixup and subtract). one event per cycle is sustained while i_ready is high.
// reset
//   synchronous active-low: config goes to its defaults, slot state clears, the step
//   returns to 10000 us and the pipeline empties.
// stall
//   when the receiver holds i_ready low with a result waiting, the whole pipeline
//   freezes; the input register still takes one more word if it is empty, then
//   o_ready drops until results drain.
`default_nettype none

module radio_timeslot_negotiator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [rtn_pkg::MODE_W-1:0]      i_mode,
    input  logic [rtn_pkg::RTC_IN_W-1:0]    i_rtc_counter,
    input  logic                            i_cfg_we,
    input  logic [rtn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rtn_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [rtn_pkg::ACT_W-1:0]       o_action,
    output logic [rtn_pkg::LEN_W-1:0]       o_extend_len_us,
    output logic [rtn_pkg::LEN_W-1:0]       o_request_len_us,
    output logic                            o_timer_armed,
    output logic [rtn_pkg::OUT_TIME_W-1:0]  o_end_deadline_us,
    output logic [rtn_pkg::OUT_TIME_W-1:0]  o_start_time_us,
    output logic [rtn_pkg::LEN_W-1:0]       o_slot_len_us,
    output logic                            o_in_slot,
    output logic                            o_slot_ended,
    output logic [rtn_pkg::FWD_W-1:0]       o_forward,
    output logic                            o_status
);
    import rtn_pkg::*;

    t_cfg                  r_cfg;

    // input register
    logic                  r_in_valid;
    logic [MODE_W-1:0]     r_in_mode;
    logic [RTC_IN_W-1:0]   r_in_rtc;

    // result pipeline
    logic                  r_v1, r_v2, r_v3, r_out_valid;
    t_result               r_s1, r_s2, r_s3, r_out;
    logic [OUT_TIME_W-1:0] r_out_dead;

    logic                  adv;
    t_result               core_res;
    logic [TIME_BITS-1:0]  deadline;

    // everything moves together unless a result is stuck at the output
    assign adv     = !r_out_valid || i_ready;
    assign o_ready = adv || !r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PPM:       r_cfg.ppm       <= i_cfg_data[PPM_W-1:0];
                CFG_MARGIN:    r_cfg.margin    <= i_cfg_data[LEN_W-1:0];
                CFG_BASE:      r_cfg.base      <= i_cfg_data[LEN_W-1:0];
                CFG_STEP:      r_cfg.step      <= i_cfg_data[LEN_W-1:0];
                CFG_EMERGENCY: r_cfg.emergency <= i_cfg_data[LEN_W-1:0];
                CFG_MAX_TOTAL: r_cfg.max_total <= i_cfg_data[LEN_W-1:0];
                CFG_MAX_FIRST: r_cfg.max_first <= i_cfg_data[LEN_W-1:0];
                CFG_MIN_RETRY: r_cfg.min_retry <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_mode <= i_mode;
            r_in_rtc  <= i_rtc_counter;
        end
    end

    // slot state steps exactly once per word, as it leaves the input register
    rtn_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_en     (adv && r_in_valid),
        .i_mode   (r_in_mode),
        .i_rtc    (r_in_rtc),
        .o_result (core_res)
    );

    // deadline stages line up with r_s2 and r_s3
    rtn_dline u_dline (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_start    (r_s1.start),
        .i_len      (r_s1.dlen),
        .i_ppm      (r_cfg.ppm),
        .i_margin   (r_cfg.margin),
        .o_deadline (deadline)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1        <= r_in_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1       <= core_res;
            r_s2       <= r_s1;
            r_s3       <= r_s2;
            r_out      <= r_s3;
            // deadline reads as zero unless this event armed the timer
            r_out_dead <= r_s3.armed ? deadline[OUT_TIME_W-1:0] : '0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_action          = r_out.action;
    assign o_extend_len_us   = r_out.ext;
    assign o_request_len_us  = r_out.req;
    assign o_timer_armed     = r_out.armed;
    assign o_end_deadline_us = r_out_dead;
    assign o_start_time_us   = r_out.start[OUT_TIME_W-1:0];
    assign o_slot_len_us     = r_out.slot_len;
    assign o_in_slot         = r_out.in_slot;
    assign o_slot_ended      = r_out.ended;
    assign o_forward         = r_out.fwd;
    assign o_status          = r_out.status;

endmodule

`default_nettype wire

// ===== hdl/rtn_checker.sv =====
// rtn_checker: port-level assertions for radio_timeslot_negotiator, bound to the top level
// depends on rtn_pkg and radio_timeslot_negotiator
`default_nettype none

module rtn_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [rtn_pkg::ACT_W-1:0]      o_action,
    input logic [rtn_pkg::LEN_W-1:0]      o_request_len_us,
    input logic                           o_timer_armed,
    input logic [rtn_pkg::OUT_TIME_W-1:0] o_end_deadline_us,
    input logic [rtn_pkg::LEN_W-1:0]      o_slot_len_us,
    input logic                           o_in_slot,
    input logic                           o_slot_ended,
    input logic                           o_status
);
    import rtn_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_action) && $stable(o_slot_len_us)
            && $stable(o_end_deadline_us))
        else $error("result changed while stalled");

    // a requested length only comes with a slot request
    a_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_request_len_us != '0) |->
            (o_action == ACT_RENEW) || (o_action == ACT_REQUEST))
        else $error("request length without request action");

    // deadline is zero unless armed
    a_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_timer_armed |-> (o_end_deadline_us == '0))
        else $error("deadline reported without arming");

    // a closed slot is no longer in progress
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_slot_ended |-> !o_in_slot)
        else $error("slot ended but still in progress");

    // resume error only inside a slot and with no action
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_in_slot && (o_action == ACT_NONE))
        else $error("bad status report");

endmodule

bind radio_timeslot_negotiator rtn_checker u_rtn_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_radio_timeslot_negotiator.sv =====
`timescale 1ns / 1ps
// tb_radio_timeslot_negotiator: self-checking bench for the radio timeslot negotiator,
// directed scheduler event sequences followed by random slot traffic under back-pressure
// depends on rtn_pkg and radio_timeslot_negotiator

module tb_radio_timeslot_negotiator;

    import rtn_pkg::*;

    // rtc ticks to microseconds and drift scale
    localparam longint unsigned US_PER_S     = 1000000;
    localparam int              RTC_HZ_SHIFT = 15;
    localparam logic [LEN_W-1:0] LEN_ALL     = '1;

    // one result word as the block should produce it
    typedef struct packed {
        t_action              action;
        logic [LEN_W-1:0]     ext_len;
        logic [LEN_W-1:0]     req_len;
        logic                 armed;
        logic [OUT_TIME_W-1:0] deadline;
        logic [OUT_TIME_W-1:0] start;
        logic [LEN_W-1:0]     len;
        logic                 in_slot;
        logic                 ended;
        t_fwd                 fwd;
        logic                 status;
    } t_slot_word;

    // dut ports, every input known from time zero
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_valid       = 1'b0;
    logic                   o_ready;
    logic [MODE_W-1:0]      i_mode        = '0;
    logic [RTC_IN_W-1:0]    i_rtc_counter = '0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   o_valid;
    logic                   i_ready       = 1'b0;
    logic [ACT_W-1:0]       o_action;
    logic [LEN_W-1:0]       o_extend_len_us;
    logic [LEN_W-1:0]       o_request_len_us;
    logic                   o_timer_armed;
    logic [OUT_TIME_W-1:0]  o_end_deadline_us;
    logic [OUT_TIME_W-1:0]  o_start_time_us;
    logic [LEN_W-1:0]       o_slot_len_us;
    logic                   o_in_slot;
    logic                   o_slot_ended;
    logic [FWD_W-1:0]       o_forward;
    logic                   o_status;

    radio_timeslot_negotiator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_rtc_counter     (i_rtc_counter),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_action          (o_action),
        .o_extend_len_us   (o_extend_len_us),
        .o_request_len_us  (o_request_len_us),
        .o_timer_armed     (o_timer_armed),
        .o_end_deadline_us (o_end_deadline_us),
        .o_start_time_us   (o_start_time_us),
        .o_slot_len_us     (o_slot_len_us),
        .o_in_slot         (o_in_slot),
        .o_slot_ended      (o_slot_ended),
        .o_forward         (o_forward),
        .o_status          (o_status)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // negotiator model: config copy and slot state
    // ------------------------------------------------------------------
    t_cfg             cfg_model;
    logic [OUT_TIME_W-1:0] slot_start;
    logic [LEN_W-1:0] slot_len;
    logic [LEN_W-1:0] ext_step;
    logic [LEN_W-1:0] ext_pending;
    logic [RTC_BITS-1:0] prev_rtc;
    logic [COUNT_W-1:0] slots_begun;
    logic             slot_open;
    logic             end_timer_hit;
    t_forced          forced;
    t_slot_word       outcome;      // word being built for the current event

    // words still owed by the block, oldest first
    t_slot_word       slot_words_due[$];

    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;
    int unsigned      events_sent;
    int unsigned      words_checked;
    int unsigned      mismatch_count;
    logic [RTC_BITS-1:0] rtc_now;

    // deadline = start + len - (len * ppm / 1e6 + margin), wrapping at 32 bits
    function automatic void arm_end_deadline();
        longint unsigned guard;
        guard = 64'(slot_len) * 64'(cfg_model.ppm) / US_PER_S + 64'(cfg_model.margin);
        outcome.deadline = OUT_TIME_W'(64'(slot_start) + 64'(slot_len) - guard);
        outcome.armed = 1'b1;
    endfunction

    // extension request, clamped so the slot stays within max_total
    function automatic void ask_extend(input logic [LEN_W-1:0] extra);
        longint unsigned amount;
        amount = 64'(extra);
        if (64'(slot_len) + amount > 64'(cfg_model.max_total)) begin
            amount = (cfg_model.max_total > slot_len) ?
                     64'(cfg_model.max_total - slot_len) : 64'd0;
        end
        outcome.action  = ACT_EXTEND;
        outcome.ext_len = LEN_W'(amount);
    endfunction

    function automatic void order_slot(input logic [LEN_W-1:0] len, input t_action act);
        outcome.action  = act;
        outcome.req_len = len;
        slot_len        = len;
    endfunction

    function automatic void close_slot();
        slot_open     = 1'b0;
        end_timer_hit = 1'b0;
        outcome.ended = 1'b1;
    endfunction

    // one scheduler event in, the word it should produce out
    function automatic t_slot_word negotiate_event(input logic [MODE_W-1:0] mode,
                                                   input logic [RTC_BITS-1:0] rtc);
        logic [RTC_BITS-1:0] ticks;
        logic [LEN_W-1:0]    limit;
        longint unsigned     grown;
        outcome = '0;
        if (mode <= MODE_EXT_FAIL) begin
            if (forced == FC_STOP) begin
                // stop pending: every slot signal just ends the slot
                outcome.action = ACT_END;
                slots_begun = '0;
                close_slot();
            end else if (forced == FC_RESTART) begin
                order_slot(cfg_model.base, ACT_RENEW);
                close_slot();
                forced = FC_NONE;
            end else begin
                case (mode)
                    MODE_START: begin
                        slot_open = 1'b1;
                        end_timer_hit = 1'b0;
                        // very first slot has no earlier rtc sample
                        if (slots_begun == '0) prev_rtc = rtc;
                        ticks = rtc - prev_rtc;
                        slot_start = slot_start +
                                     OUT_TIME_W'((64'(ticks) * US_PER_S) >> RTC_HZ_SHIFT);
                        prev_rtc = rtc;
                        ext_step = cfg_model.step;
                        arm_end_deadline();
                        ask_extend(ext_step);
                        slots_begun = slots_begun + 1'b1;
                        if (slots_begun == '0) slots_begun = 1;
                    end
                    MODE_RADIO: outcome.fwd = FWD_RADIO;
                    MODE_TIMER: outcome.fwd = FWD_TIMER;
                    MODE_EXT_OK: begin
                        grown = 64'(slot_len) + 64'(ext_pending);
                        slot_len = (grown > 64'(LEN_ALL)) ? LEN_ALL : LEN_W'(grown);
                        ext_pending = '0;
                        arm_end_deadline();
                        // the first slot after start has its own tighter limit
                        limit = (slots_begun == 1) ? cfg_model.max_first : cfg_model.max_total;
                        if (64'(slot_len) + 64'(ext_step) < 64'(limit)) ask_extend(ext_step);
                    end
                    default: begin
                        // refusal: halve the step, retry only above the floor
                        ext_step = ext_step >> 1;
                        if (ext_step > cfg_model.min_retry) ask_extend(ext_step);
                    end
                endcase
                if (end_timer_hit) begin
                    order_slot(cfg_model.base, ACT_RENEW);
                    close_slot();
                end else if (outcome.action == ACT_EXTEND) begin
                    ext_pending = outcome.ext_len;
                end else begin
                    ext_pending = '0;
                end
            end
        end else begin
            case (mode)
                MODE_END_TIMER: end_timer_hit = 1'b1;
                MODE_IDLE: if (forced != FC_STOP) order_slot(cfg_model.base, ACT_REQUEST);
                MODE_BLOCKED: order_slot(cfg_model.emergency, ACT_REQUEST);
                MODE_CANCELLED: order_slot(cfg_model.base, ACT_REQUEST);
                MODE_STOP: forced = FC_STOP;
                MODE_RESTART: forced = FC_RESTART;
                MODE_RESUME: begin
                    forced = FC_NONE;
                    if (slot_open) outcome.status = 1'b1;
                    else order_slot(cfg_model.base, ACT_REQUEST);
                end
                default: ;
            endcase
        end
        outcome.start   = slot_start;
        outcome.len     = slot_len;
        outcome.in_slot = slot_open;
        return outcome;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) $display("mismatch at word %0d: %s", words_checked, what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
        end
    endtask

    // outputs sampled at the rising edge, word taken when o_valid and i_ready
    always @(posedge i_clk) begin
        t_slot_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (slot_words_due.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                want = slot_words_due.pop_front();
                compare_field("action",   32'(want.action),   32'(o_action));
                compare_field("extend",   32'(want.ext_len),  32'(o_extend_len_us));
                compare_field("request",  32'(want.req_len),  32'(o_request_len_us));
                compare_field("armed",    32'(want.armed),    32'(o_timer_armed));
                compare_field("deadline", want.deadline,      o_end_deadline_us);
                compare_field("start",    want.start,         o_start_time_us);
                compare_field("slot_len", 32'(want.len),      32'(o_slot_len_us));
                compare_field("in_slot",  32'(want.in_slot),  32'(o_in_slot));
                compare_field("ended",    32'(want.ended),    32'(o_slot_ended));
                compare_field("forward",  32'(want.fwd),      32'(o_forward));
                compare_field("status",   32'(want.status),   32'(o_status));
            end
            words_checked++;
        end
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // stimulus helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------

    // one event word; valid held until the block takes it
    task automatic send_event(input logic [MODE_W-1:0] mode, input logic [RTC_BITS-1:0] rtc);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_rtc_counter <= rtc;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        slot_words_due.push_back(negotiate_event(mode, rtc));
        if (mode <= MODE_RESUME) events_sent++;
        @(negedge i_clk);
    endtask

    // let every outstanding word come back, then let the pipeline settle
    task automatic drain_results();
        i_valid <= 1'b0;
        while (slot_words_due.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    // full register set, only while nothing is in flight
    task automatic load_config(input t_cfg c);
        write_reg(CFG_PPM,       CFG_DATA_W'(c.ppm));
        write_reg(CFG_MARGIN,    c.margin);
        write_reg(CFG_BASE,      c.base);
        write_reg(CFG_STEP,      c.step);
        write_reg(CFG_EMERGENCY, c.emergency);
        write_reg(CFG_MAX_TOTAL, c.max_total);
        write_reg(CFG_MAX_FIRST, c.max_first);
        write_reg(CFG_MIN_RETRY, c.min_retry);
        i_cfg_we <= 1'b0;
        cfg_model = c;
    endtask

    // lengths lean toward values that keep negotiation going, edges now and then
    function automatic logic [LEN_W-1:0] pick_len(input int unsigned lo, input int unsigned hi);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) return '0;
        if (roll < 16) return LEN_ALL;
        return LEN_W'($urandom_range(hi, lo));
    endfunction

    function automatic t_cfg random_config();
        t_cfg c;
        int unsigned roll;
        roll = $urandom_range(99);
        c.ppm       = (roll < 15) ? PPM_W'(20) : (roll < 30) ? PPM_W'(500) :
                      PPM_W'($urandom_range(500, 20));
        c.margin    = pick_len(0, 5000);
        c.base      = pick_len(100, 50000);
        c.step      = pick_len(100, 100000);
        c.emergency = pick_len(100, 20000);
        c.max_total = pick_len(1000, 2000000);
        c.max_first = pick_len(0, 100000);
        c.min_retry = pick_len(0, 5000);
        return c;
    endfunction

    // start, a run of in-slot signals, sometimes closed by the end timer
    task automatic send_slot_sequence();
        int unsigned roll;
        logic [MODE_W-1:0] mode;
        roll = $urandom_range(99);
        if (roll < 70) rtc_now = rtc_now + RTC_BITS'($urandom_range(2000, 1));
        else if (roll < 90) rtc_now = RTC_BITS'($urandom);
        send_event(MODE_START, rtc_now);
        repeat ($urandom_range(8, 1)) begin
            roll = $urandom_range(99);
            if (roll < 40) mode = MODE_EXT_OK;
            else if (roll < 70) mode = MODE_EXT_FAIL;
            else if (roll < 80) mode = MODE_RADIO;
            else if (roll < 90) mode = MODE_TIMER;
            else if (roll < 93) mode = MODE_IDLE;
            else if (roll < 96) mode = MODE_BLOCKED;
            else if (roll < 98) mode = MODE_CANCELLED;
            else mode = MODE_RESUME;
            send_event(mode, RTC_BITS'($urandom));
        end
        if ($urandom_range(3) == 0) begin
            send_event(MODE_END_TIMER, RTC_BITS'($urandom));
            send_event(MODE_W'($urandom_range(4, 1)), RTC_BITS'($urandom));
        end
    endtask

    // stop, restart and resume handling between slots, with idle, blocked, cancelled and end timer events
    task automatic send_scheduler_burst();
        case ($urandom_range(4))
            0: send_event(MODE_W'($urandom_range(8, 6)), RTC_BITS'($urandom));
            1: begin
                send_event(MODE_STOP, RTC_BITS'($urandom));
                repeat ($urandom_range(3)) begin
                    send_event(MODE_W'($urandom_range(4, 0)), RTC_BITS'($urandom));
                end
                if ($urandom_range(1) == 0) send_event(MODE_IDLE, RTC_BITS'($urandom));
                send_event(MODE_RESUME, RTC_BITS'($urandom));
            end
            2: begin
                send_event(MODE_RESTART, RTC_BITS'($urandom));
                send_event(MODE_W'($urandom_range(4, 0)), RTC_BITS'($urandom));
            end
            3: send_event(MODE_RESUME, RTC_BITS'($urandom));
            default: begin
                send_event(MODE_END_TIMER, RTC_BITS'($urandom));
                send_event(MODE_W'($urandom_range(8, 6)), RTC_BITS'($urandom));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // slot start, extension grant and refusal chain, rtc wrap, end timer
    task automatic test_slot_flow();
        send_event(MODE_START, 24'hABCDEF);       // first start, delta forced to zero
        send_event(MODE_EXT_OK, 24'h000000);      // first slot limit blocks further asks
        repeat (4) send_event(MODE_EXT_FAIL, 24'h000000);  // halve down past the floor
        send_event(MODE_RADIO, 24'h000000);
        send_event(MODE_TIMER, 24'h000000);
        send_event(MODE_START, 24'h000123);       // rtc rolled over since last start
        send_event(MODE_EXT_OK, 24'h000000);
        send_event(MODE_EXT_OK, 24'h000000);
        send_event(MODE_END_TIMER, 24'h000000);
        send_event(MODE_EXT_FAIL, 24'h000000);    // end timer turns this into a renew
        send_event(MODE_END_TIMER, 24'h000000);   // outside a slot, still remembered
        send_event(MODE_RADIO, 24'h000000);
        drain_results();
    endtask

    // idle, blocked, cancelled, stop, restart, resume and unknown codes
    task automatic test_scheduler_events();
        send_event(MODE_IDLE, 24'h000000);
        send_event(MODE_BLOCKED, 24'h000000);
        send_event(MODE_CANCELLED, 24'h000000);
        send_event(MODE_RESUME, 24'h000000);
        send_event(MODE_START, 24'h000800);
        send_event(MODE_RESUME, 24'h000000);      // resume in a slot flags status
        send_event(MODE_STOP, 24'h000000);
        send_event(MODE_START, 24'h001000);       // forced stop ends it
        send_event(MODE_IDLE, 24'h000000);        // idle while stopped asks nothing
        send_event(MODE_RESTART, 24'h000000);
        send_event(MODE_TIMER, 24'h000000);       // forced restart renews
        send_event(4'd12, 24'hFFFFFF);
        send_event(4'd15, 24'hFFFFFF);
        drain_results();
    endtask

    // clamp below zero, length saturation and both config extremes
    task automatic test_limits();
        t_cfg c;
        c = CFG_RESET;
        c.max_total = 100;
        c.base = 5000;
        load_config(c);
        send_event(MODE_IDLE, 24'h000000);        // slot length now above the total limit
        send_event(MODE_START, 24'h002000);       // clamped extension comes out zero
        drain_results();
        c = '{ppm: PPM_W'(500), margin: LEN_ALL, base: LEN_ALL, step: LEN_ALL,
              emergency: LEN_ALL, max_total: LEN_ALL, max_first: LEN_ALL, min_retry: LEN_ALL};
        load_config(c);
        send_event(MODE_START, 24'hFFFFFF);
        send_event(MODE_IDLE, 24'h000000);        // grows the slot under the pending ask
        send_event(MODE_EXT_OK, 24'h000000);      // grant saturates the length
        send_event(MODE_BLOCKED, 24'h000000);
        drain_results();
        c = '{ppm: PPM_W'(20), margin: '0, base: '0, step: '0,
              emergency: '0, max_total: '0, max_first: '0, min_retry: '0};
        load_config(c);
        send_event(MODE_START, 24'h000000);
        send_event(MODE_EXT_FAIL, 24'h000000);
        drain_results();
    endtask

    // random traffic over several register settings at one idling mix
    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
        int unsigned stop_at;
        int unsigned roll;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int s = 0; s < 3; s++) begin
            drain_results();
            load_config((s == 2) ? CFG_RESET : random_config());
            stop_at = events_sent + 200;
            while (events_sent < stop_at) begin
                roll = $urandom_range(99);
                if (roll < 65) send_slot_sequence();
                else if (roll < 85) send_scheduler_burst();
                else send_event(MODE_W'($urandom_range(15)), RTC_BITS'($urandom));
            end
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_model      = CFG_RESET;
        slot_start     = '0;
        slot_len       = '0;
        ext_step       = CFG_RESET.base;
        ext_pending    = '0;
        prev_rtc       = '0;
        slots_begun    = '0;
        slot_open      = 1'b0;
        end_timer_hit  = 1'b0;
        forced         = FC_NONE;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        events_sent    = 0;
        words_checked  = 0;
        mismatch_count = 0;
        rtc_now        = '0;

        // reset held across rising edges, then released on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_slot_flow();
        test_scheduler_events();
        test_limits();
        test_random_traffic(38, 65);
        test_random_traffic(65, 38);
        test_random_traffic(0, 0);

        drain_results();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rtn_pkg.sv
hdl/rtn_core.sv
hdl/rtn_dline.sv
hdl/radio_timeslot_negotiator.sv
hdl/rtn_checker.sv
tb/sv/tb_radio_timeslot_negotiator.sv
